/* design/qrs_pkg.sv */
// Shared types and constants for the quadratic root solver.
package qrs_pkg;

  localparam int ROOT_W = 48;
  localparam int KIND_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE   = 2'd0,
    KIND_SINGLE = 2'd1,
    KIND_TWO    = 2'd2
  } root_kind_e;

endpackage

/* design/qrs_in_if.sv */
// Coefficient channel: valid/ready handshake with the three coefficients.
interface qrs_in_if #(
  parameter int CW = 16
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] coef_a;
  logic [CW-1:0] coef_b;
  logic [CW-1:0] coef_c;

  modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
  modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

/* design/qrs_out_if.sv */
// Result channel: valid/ready handshake with the root kind, both roots and the flag.
interface qrs_out_if;
  logic                       valid;
  logic                       ready;
  logic [qrs_pkg::KIND_W-1:0] root_kind;
  logic [qrs_pkg::ROOT_W-1:0] root_first;
  logic [qrs_pkg::ROOT_W-1:0] root_second;
  logic                       degenerate;

  modport source (output valid, output root_kind, output root_first, output root_second,
                  output degenerate, input ready);
  modport sink   (input valid, input root_kind, input root_first, input root_second,
                  input degenerate, output ready);
endinterface

/* design/qrs_front.sv */
// Front stages: sign split, products, discriminant, case selection and radicand.
module qrs_front import qrs_pkg::*; #(
  parameter int CW     = 16,
  parameter int F      = 16,
  parameter int SQ_W   = 33,
  parameter int NUM_W  = 35,
  parameter int DEN_W  = 17,
  parameter int SIDE_W = 5 + 2 * 35 + 17
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [CW-1:0]     coef_a_i,
  input  logic [CW-1:0]     coef_b_i,
  input  logic [CW-1:0]     coef_c_i,
  output logic              valid_o,
  output logic [2*SQ_W-1:0] rad_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int PROD_W   = 2 * CW - 1;
  localparam int DLT_W    = 2 * CW + 1;
  localparam int RAD_FULL = DLT_W + 2 * F;
  localparam int RAD_W    = (RAD_FULL > 128) ? 128 : RAD_FULL;
  localparam int RAD_PW   = 2 * SQ_W;

  // Stage A: signs and magnitudes.
  logic          a_valid_q;
  logic          na_q, nb_q, nc_q;
  logic [CW-1:0] ma_q, mb_q, mc_q;
  logic [CW-1:0] ma_d, mb_d, mc_d;

  assign ma_d = coef_a_i[CW-1] ? (~coef_a_i + CW'(1)) : coef_a_i;
  assign mb_d = coef_b_i[CW-1] ? (~coef_b_i + CW'(1)) : coef_b_i;
  assign mc_d = coef_c_i[CW-1] ? (~coef_c_i + CW'(1)) : coef_c_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      na_q <= coef_a_i[CW-1];
      nb_q <= coef_b_i[CW-1];
      nc_q <= coef_c_i[CW-1];
      ma_q <= ma_d;
      mb_q <= mb_d;
      mc_q <= mc_d;
    end
  end

  // Stage B: b*b and a*c on magnitudes.
  logic              b_valid_q;
  logic              b_na_q, b_nb_q, b_nc_q;
  logic [CW-1:0]     b_ma_q, b_mb_q, b_mc_q;
  logic [PROD_W-1:0] bb_q, ac_q;
  logic [2*CW-1:0]   bb_full, ac_full;

  assign bb_full = (2*CW)'(mb_q) * (2*CW)'(mb_q);
  assign ac_full = (2*CW)'(ma_q) * (2*CW)'(mc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_na_q <= na_q;
      b_nb_q <= nb_q;
      b_nc_q <= nc_q;
      b_ma_q <= ma_q;
      b_mb_q <= mb_q;
      b_mc_q <= mc_q;
      bb_q   <= bb_full[PROD_W-1:0];
      ac_q   <= ac_full[PROD_W-1:0];
    end
  end

  // Stage C: discriminant sign and the numerator/denominator set-up.
  logic [DLT_W-1:0]    bb_ext, four_ac, delta;
  logic                add_case, pos, zero;
  logic [RAD_FULL-1:0] rad_full;
  logic [RAD_PW-1:0]   rad_d;
  root_kind_e          kind;
  logic                degen, neg_pre;
  logic [NUM_W-1:0]    bs, negb, mag_pre;
  logic [DEN_W-1:0]    den;
  logic                c_valid_q;
  logic [RAD_PW-1:0]   rad_q;
  logic [SIDE_W-1:0]   side_q;

  assign bb_ext   = DLT_W'(bb_q);
  assign four_ac  = {ac_q, 2'b00};
  // Opposite signs of a and c make -4ac positive, so delta is a plain sum.
  assign add_case = (ac_q != '0) && (b_na_q != b_nc_q);
  assign pos      = add_case || (bb_ext > four_ac);
  assign zero     = !add_case && (bb_ext == four_ac);
  assign delta    = add_case ? (bb_ext + four_ac) : (bb_ext - four_ac);
  assign rad_full = RAD_FULL'(delta) << (2 * F);
  assign rad_d    = RAD_PW'(rad_full[RAD_W-1:0]);
  assign bs       = NUM_W'(b_mb_q) << F;
  assign negb     = b_nb_q ? bs : (~bs + NUM_W'(1));

  always_comb begin
    kind    = KIND_NONE;
    degen   = 1'b0;
    neg_pre = 1'b0;
    mag_pre = '0;
    den     = DEN_W'(1);
    if (b_ma_q == '0) begin
      if (b_mb_q == '0) begin
        degen = 1'b1;
      end else begin
        kind    = KIND_SINGLE;
        mag_pre = NUM_W'(b_mc_q) << F;
        neg_pre = (b_mc_q != '0) && (b_nc_q == b_nb_q);
        den     = DEN_W'(b_mb_q);
      end
    end else if (pos) begin
      kind = KIND_TWO;
      den  = DEN_W'(b_ma_q) << 1;
    end else if (zero) begin
      kind    = KIND_SINGLE;
      mag_pre = NUM_W'(b_mb_q) << F;
      neg_pre = (b_mb_q != '0) && (b_nb_q == b_na_q);
      den     = DEN_W'(b_ma_q) << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      side_q <= {kind, degen, neg_pre, b_na_q, negb, mag_pre, den};
    end
  end

  assign valid_o = c_valid_q;
  assign rad_o   = rad_q;
  assign side_o  = side_q;

endmodule

/* design/qrs_sqrt_cell.sv */
// One square root cell: settles one root bit from two radicand bits.
module qrs_sqrt_cell #(
  parameter int SQ_W   = 33,
  parameter int SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [2*SQ_W-1:0] rad_i,
  input  logic [SQ_W+1:0]   rem_i,
  input  logic [SQ_W-1:0]   root_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [2*SQ_W-1:0] rad_o,
  output logic [SQ_W+1:0]   rem_o,
  output logic [SQ_W-1:0]   root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int RAD_PW = 2 * SQ_W;

  logic [SQ_W+3:0] rem_sh, trial, diff;
  logic            ge;

  assign rem_sh = {rem_i, rad_i[RAD_PW-1 -: 2]};
  assign trial  = (SQ_W+4)'({root_i, 2'b01});
  assign ge     = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= {rad_i[RAD_PW-3:0], 2'b00};
      rem_o  <= ge ? diff[SQ_W+1:0] : rem_sh[SQ_W+1:0];
      root_o <= {root_i[SQ_W-2:0], ge};
      side_o <= side_i;
    end
  end

endmodule

/* design/qrs_div_cell.sv */
// One divider cell: settles one quotient bit by restoring subtraction.
module qrs_div_cell #(
  parameter int NUM_W  = 35,
  parameter int DEN_W  = 17,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DEN_W-1:0]  rem_i,
  input  logic [NUM_W-1:0]  nq_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [DEN_W-1:0]  rem_o,
  output logic [NUM_W-1:0]  nq_o,
  output logic [DEN_W-1:0]  den_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [DEN_W:0] rem_sh, diff;
  logic           ge;

  // The numerator drains from the top while quotient bits fill the bottom.
  assign rem_sh = {rem_i, nq_i[NUM_W-1]};
  assign ge     = rem_sh >= (DEN_W+1)'(den_i);
  assign diff   = rem_sh - (DEN_W+1)'(den_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      nq_o   <= {nq_i[NUM_W-2:0], ge};
      den_o  <= den_i;
      side_o <= side_i;
    end
  end

endmodule

/* design/quadratic_root_solver.sv */
// Top level of the quadratic root solver: front stages, square root row, two divider rows.
//
//   channel  dir  payload
//   in_i     in   coef_a, coef_b, coef_c (COEF_WIDTH bits, signed)
//   out_o    out  root_kind, root_first, root_second (Q FRAC_BITS), degenerate
//
// One item enters per cycle while out_o does not stall. Each item passes the front stages,
// the row of square root cells (one per root bit), the numerator stage, the rows of divider
// cells (one per quotient bit) and the output register.
// Reset clears only the valid bits of the stages.
// When a result waits and out_o.ready is low, every stage holds and in_i.ready drops.
module quadratic_root_solver import qrs_pkg::*; #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  qrs_in_if.sink      in_i,
  qrs_out_if.source   out_o
);

  localparam int CW       = COEF_WIDTH;
  localparam int F        = FRAC_BITS;
  localparam int DLT_W    = 2 * CW + 1;
  localparam int RAD_FULL = DLT_W + 2 * F;
  localparam int RAD_W    = (RAD_FULL > 128) ? 128 : RAD_FULL;
  localparam int SQ_W     = (RAD_W + 1) / 2;
  localparam int NUM_B    = (CW - 1 + F > SQ_W) ? (CW - 1 + F) : SQ_W;
  localparam int NUM_W    = (NUM_B + 2 > 64) ? 64 : (NUM_B + 2);
  localparam int DEN_W    = CW + 1;
  localparam int SIDE_W   = 5 + 2 * NUM_W + DEN_W;
  localparam int S1_W     = KIND_W + 2;

  logic en;

  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // Front.
  logic              f_valid;
  logic [2*SQ_W-1:0] f_rad;
  logic [SIDE_W-1:0] f_side;

  qrs_front #(
    .CW(CW), .F(F), .SQ_W(SQ_W), .NUM_W(NUM_W), .DEN_W(DEN_W), .SIDE_W(SIDE_W)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_i.valid),
    .coef_a_i (in_i.coef_a),
    .coef_b_i (in_i.coef_b),
    .coef_c_i (in_i.coef_c),
    .valid_o  (f_valid),
    .rad_o    (f_rad),
    .side_o   (f_side)
  );

  // Square root row.
  logic              sq_valid [SQ_W+1];
  logic [2*SQ_W-1:0] sq_rad   [SQ_W+1];
  logic [SQ_W+1:0]   sq_rem   [SQ_W+1];
  logic [SQ_W-1:0]   sq_root  [SQ_W+1];
  logic [SIDE_W-1:0] sq_side  [SQ_W+1];

  assign sq_valid[0] = f_valid;
  assign sq_rad[0]   = f_rad;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_side[0]  = f_side;

  for (genvar i = 0; i < SQ_W; i++) begin : g_sqrt
    qrs_sqrt_cell #(.SQ_W(SQ_W), .SIDE_W(SIDE_W)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_valid[i]),
      .rad_i   (sq_rad[i]),
      .rem_i   (sq_rem[i]),
      .root_i  (sq_root[i]),
      .side_i  (sq_side[i]),
      .valid_o (sq_valid[i+1]),
      .rad_o   (sq_rad[i+1]),
      .rem_o   (sq_rem[i+1]),
      .root_o  (sq_root[i+1]),
      .side_o  (sq_side[i+1])
    );
  end

  // Numerator stage: for two roots, forms -b*2^F -/+ s and splits both into sign and magnitude.
  logic [KIND_W-1:0] s_kind;
  logic              s_degen, s_neg_pre, s_na;
  logic [NUM_W-1:0]  s_negb, s_mag_pre;
  logic [DEN_W-1:0]  s_den;
  logic [NUM_W-1:0]  sroot, n1, n2, mag1_d, mag2_d;
  logic              neg1_d, neg2_d;

  assign {s_kind, s_degen, s_neg_pre, s_na, s_negb, s_mag_pre, s_den} = sq_side[SQ_W];
  assign sroot = NUM_W'(sq_root[SQ_W]);
  assign n1    = s_negb - sroot;
  assign n2    = s_negb + sroot;

  always_comb begin
    mag1_d = s_mag_pre;
    mag2_d = s_mag_pre;
    neg1_d = s_neg_pre;
    neg2_d = s_neg_pre;
    if (s_kind == KIND_TWO) begin
      mag1_d = n1[NUM_W-1] ? (~n1 + NUM_W'(1)) : n1;
      mag2_d = n2[NUM_W-1] ? (~n2 + NUM_W'(1)) : n2;
      neg1_d = n1[NUM_W-1] ^ s_na;
      neg2_d = n2[NUM_W-1] ^ s_na;
    end
  end

  logic             p_valid_q;
  logic [NUM_W-1:0] p_mag1_q, p_mag2_q;
  logic [DEN_W-1:0] p_den_q;
  logic [S1_W-1:0]  p_side1_q;
  logic             p_neg2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (en) begin
      p_valid_q <= sq_valid[SQ_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_mag1_q  <= mag1_d;
      p_mag2_q  <= mag2_d;
      p_den_q   <= s_den;
      p_side1_q <= {s_kind, s_degen, neg1_d};
      p_neg2_q  <= neg2_d;
    end
  end

  // Two divider rows, one for each root.
  logic             d1_valid [NUM_W+1];
  logic [DEN_W-1:0] d1_rem   [NUM_W+1];
  logic [NUM_W-1:0] d1_nq    [NUM_W+1];
  logic [DEN_W-1:0] d1_den   [NUM_W+1];
  logic [S1_W-1:0]  d1_side  [NUM_W+1];
  logic             d2_valid [NUM_W+1];
  logic [DEN_W-1:0] d2_rem   [NUM_W+1];
  logic [NUM_W-1:0] d2_nq    [NUM_W+1];
  logic [DEN_W-1:0] d2_den   [NUM_W+1];
  logic [0:0]       d2_side  [NUM_W+1];

  assign d1_valid[0] = p_valid_q;
  assign d1_rem[0]   = '0;
  assign d1_nq[0]    = p_mag1_q;
  assign d1_den[0]   = p_den_q;
  assign d1_side[0]  = p_side1_q;
  assign d2_valid[0] = p_valid_q;
  assign d2_rem[0]   = '0;
  assign d2_nq[0]    = p_mag2_q;
  assign d2_den[0]   = p_den_q;
  assign d2_side[0]  = p_neg2_q;

  for (genvar i = 0; i < NUM_W; i++) begin : g_div
    qrs_div_cell #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SIDE_W(S1_W)) u_first (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (d1_valid[i]),
      .rem_i   (d1_rem[i]),
      .nq_i    (d1_nq[i]),
      .den_i   (d1_den[i]),
      .side_i  (d1_side[i]),
      .valid_o (d1_valid[i+1]),
      .rem_o   (d1_rem[i+1]),
      .nq_o    (d1_nq[i+1]),
      .den_o   (d1_den[i+1]),
      .side_o  (d1_side[i+1])
    );
    qrs_div_cell #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SIDE_W(1)) u_second (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (d2_valid[i]),
      .rem_i   (d2_rem[i]),
      .nq_i    (d2_nq[i]),
      .den_i   (d2_den[i]),
      .side_i  (d2_side[i]),
      .valid_o (d2_valid[i+1]),
      .rem_o   (d2_rem[i+1]),
      .nq_o    (d2_nq[i+1]),
      .den_o   (d2_den[i+1]),
      .side_o  (d2_side[i+1])
    );
  end

  // Output register: apply the signs and wrap to the root width.
  logic [KIND_W-1:0] e_kind;
  logic              e_degen, e_neg1;
  logic [ROOT_W-1:0] q1, q2;
  logic              out_valid_q;
  logic [KIND_W-1:0] kind_q;
  logic              degen_q;
  logic [ROOT_W-1:0] root1_q, root2_q;

  assign {e_kind, e_degen, e_neg1} = d1_side[NUM_W];
  assign q1 = ROOT_W'(d1_nq[NUM_W]);
  assign q2 = ROOT_W'(d2_nq[NUM_W]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d1_valid[NUM_W] && d2_valid[NUM_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind_q  <= e_kind;
      degen_q <= e_degen;
      root1_q <= e_neg1 ? (~q1 + ROOT_W'(1)) : q1;
      root2_q <= d2_side[NUM_W][0] ? (~q2 + ROOT_W'(1)) : q2;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.root_kind   = kind_q;
  assign out_o.root_first  = root1_q;
  assign out_o.root_second = root2_q;
  assign out_o.degenerate  = degen_q;

  // A degenerate equation never reports a root.
  a_degen_no_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.degenerate) |-> (out_o.root_kind == KIND_NONE))
    else $error("degenerate item reports a root");

  // No root means both root fields are zero.
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.root_kind == KIND_NONE) |->
      (out_o.root_first == '0 && out_o.root_second == '0))
    else $error("root fields not cleared without a root");

  // A single root appears in both fields.
  a_single_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.root_kind == KIND_SINGLE) |->
      (out_o.root_first == out_o.root_second))
    else $error("single root differs between fields");

  // The two divider rows stay in step.
  a_rows_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d1_valid[NUM_W] == d2_valid[NUM_W])
    else $error("divider rows out of step");

endmodule
